// ===== rtl/core/afne_pkg.sv =====
// afne_pkg: shared types and constants for the archive file name extractor
// depends on nothing; used by every rtl/core module
package afne_pkg;

   localparam int OFFSET_W = 33;

   // parser phase codes
   localparam logic [1:0] PH_PRELUDE = 2'd0;
   localparam logic [1:0] PH_BLOCK   = 2'd1;
   localparam logic [1:0] PH_HALTED  = 2'd2;

   localparam logic [7:0] KIND_FILE       = 8'h74;
   localparam logic [7:0] PRELUDE_DEFAULT = 8'd22;

   // byte offsets inside a block, counted from the type byte
   localparam logic [OFFSET_W-1:0] OFF_HEAD_LO    = 33'd3;
   localparam logic [OFFSET_W-1:0] OFF_HEAD_HI    = 33'd4;
   localparam logic [OFFSET_W-1:0] OFF_PACK_FIRST = 33'd5;
   localparam logic [OFFSET_W-1:0] OFF_PACK_LAST  = 33'd8;
   localparam logic [OFFSET_W-1:0] OFF_NAMELEN_LO = 33'd24;
   localparam logic [OFFSET_W-1:0] OFF_NAMELEN_HI = 33'd25;
   localparam logic [OFFSET_W-1:0] OFF_NAME       = 33'd30;

   // bytes that must be read before the block step is known
   localparam logic [OFFSET_W-1:0] NEED_OTHER = 33'd5;
   localparam logic [OFFSET_W-1:0] NEED_FILE  = 33'd9;

   typedef struct packed {
      logic       valid;
      logic [7:0] name_byte;
      logic       name_end;
   } name_result_type;

endpackage

// ===== rtl/core/afne_ifs.sv =====
// afne_ifs: valid/ready channel interfaces for archive bytes and name bytes
// no dependencies
interface afne_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] archive_byte;
   logic       end_of_archive;

   modport source (output valid, output archive_byte, output end_of_archive, input ready);
   modport sink   (input valid, input archive_byte, input end_of_archive, output ready);
endinterface

interface afne_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] name_byte;
   logic       name_end;

   modport source (output valid, output name_byte, output name_end, input ready);
   modport sink   (input valid, input name_byte, input name_end, output ready);
endinterface

// ===== rtl/core/afne_parse.sv =====
// afne_parse: block chain walker state and per-byte next-state logic
// depends on afne_pkg
module afne_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [7:0]                archive_byte,
   input  logic                      end_of_archive,
   input  logic [7:0]                prelude_length,
   output afne_pkg::name_result_type result
);

   logic [1:0]                      phase_ff, phase_in;
   logic [7:0]                      prelude_count_ff, prelude_count_in;
   logic [afne_pkg::OFFSET_W-1:0]   block_offset_ff, block_offset_in;
   logic [7:0]                      block_kind_ff, block_kind_in;
   logic [15:0]                     header_bytes_ff, header_bytes_in;
   logic [31:0]                     payload_bytes_ff, payload_bytes_in;
   logic [15:0]                     name_length_ff, name_length_in;

   logic                            in_block;
   logic                            is_file;
   logic [afne_pkg::OFFSET_W-1:0]   offset;
   logic [afne_pkg::OFFSET_W-1:0]   offset_next;
   logic [afne_pkg::OFFSET_W-1:0]   step;
   logic [afne_pkg::OFFSET_W-1:0]   need;
   logic [afne_pkg::OFFSET_W-1:0]   name_stop;
   logic [afne_pkg::OFFSET_W-1:0]   stop;
   logic [1:0]                      lane;

   always_comb begin
      phase_in         = phase_ff;
      prelude_count_in = prelude_count_ff;
      block_kind_in    = block_kind_ff;
      header_bytes_in  = header_bytes_ff;
      payload_bytes_in = payload_bytes_ff;
      name_length_in   = name_length_ff;
      block_offset_in  = block_offset_ff;
      result           = '0;
      in_block         = 1'b0;
      offset           = block_offset_ff;

      // prelude skip; the byte that ends it is already the first type byte
      if (phase_ff == afne_pkg::PH_PRELUDE) begin
         if (prelude_count_ff < prelude_length) begin
            prelude_count_in = 8'(prelude_count_ff + 8'd1);
         end else begin
            phase_in = afne_pkg::PH_BLOCK;
            offset   = '0;
            in_block = 1'b1;
         end
      end else if (phase_ff == afne_pkg::PH_BLOCK) begin
         in_block = 1'b1;
      end

      if (offset == '0) begin
         block_kind_in = archive_byte;
      end
      is_file = (block_kind_in == afne_pkg::KIND_FILE);
      lane    = 2'(offset - afne_pkg::OFF_PACK_FIRST);

      if (offset == '0) begin
         header_bytes_in  = '0;
         payload_bytes_in = '0;
         name_length_in   = '0;
      end else if (offset == afne_pkg::OFF_HEAD_LO) begin
         header_bytes_in[7:0] = archive_byte;
      end else if (offset == afne_pkg::OFF_HEAD_HI) begin
         header_bytes_in[15:8] = archive_byte;
      end else if (is_file && offset >= afne_pkg::OFF_PACK_FIRST
                   && offset <= afne_pkg::OFF_PACK_LAST) begin
         payload_bytes_in[{lane, 3'b000} +: 8] = archive_byte;
      end else if (is_file && offset == afne_pkg::OFF_NAMELEN_LO) begin
         name_length_in[7:0] = archive_byte;
      end else if (is_file && offset == afne_pkg::OFF_NAMELEN_HI) begin
         name_length_in[15:8] = archive_byte;
      end

      // head size, plus pack size for file blocks
      step = afne_pkg::OFFSET_W'(header_bytes_in)
           + (is_file ? afne_pkg::OFFSET_W'(payload_bytes_in) : '0);

      name_stop   = afne_pkg::OFF_NAME + afne_pkg::OFFSET_W'(name_length_ff);
      stop        = (name_stop < step) ? name_stop : step;
      offset_next = afne_pkg::OFFSET_W'(offset + 33'd1);
      need        = is_file ? afne_pkg::NEED_FILE : afne_pkg::NEED_OTHER;

      if (in_block) begin
         if (is_file && offset >= afne_pkg::OFF_NAME && offset < name_stop) begin
            result.valid     = 1'b1;
            result.name_byte = archive_byte;
            result.name_end  = (offset_next == stop);
         end
         block_offset_in = offset_next;
         if (offset_next >= need) begin
            if (step == '0) begin
               phase_in = afne_pkg::PH_HALTED;
            end else if (offset_next >= step) begin
               block_offset_in = '0;
            end
         end
      end else begin
         block_kind_in    = block_kind_ff;
         header_bytes_in  = header_bytes_ff;
         payload_bytes_in = payload_bytes_ff;
         name_length_in   = name_length_ff;
      end

      // last byte of the archive: back to the prelude
      if (end_of_archive) begin
         phase_in         = afne_pkg::PH_PRELUDE;
         prelude_count_in = '0;
         block_offset_in  = '0;
         block_kind_in    = '0;
         header_bytes_in  = '0;
         payload_bytes_in = '0;
         name_length_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= afne_pkg::PH_PRELUDE;
         prelude_count_ff <= '0;
         block_offset_ff  <= '0;
         block_kind_ff    <= '0;
         header_bytes_ff  <= '0;
         payload_bytes_ff <= '0;
         name_length_ff   <= '0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         prelude_count_ff <= prelude_count_in;
         block_offset_ff  <= block_offset_in;
         block_kind_ff    <= block_kind_in;
         header_bytes_ff  <= header_bytes_in;
         payload_bytes_ff <= payload_bytes_in;
         name_length_ff   <= name_length_in;
      end
   end

endmodule

// ===== rtl/core/afne_out_reg.sv =====
// afne_out_reg: result register driving the name byte channel
// depends on afne_pkg and afne_rsp_if
module afne_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  afne_pkg::name_result_type result,
   output logic                      out_free,
   afne_rsp_if.source                rsp_chan
);

   logic       valid_ff, valid_in;
   logic [7:0] name_byte_ff;
   logic       name_end_ff;

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         name_byte_ff <= result.name_byte;
         name_end_ff  <= result.name_end;
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.name_byte = name_byte_ff;
   assign rsp_chan.name_end  = name_end_ff;

endmodule

// ===== rtl/core/archive_file_name_extractor_top.sv =====
// archive_file_name_extractor_top: lists stored file names of a block-chained archive
// depends on afne_pkg, afne_ifs, afne_parse and afne_out_reg
//
//   channel    direction  handshake               carries
//   req_chan   in         valid/ready             archive_byte, end_of_archive
//   rsp_chan   out        valid/ready             name_byte, name_end
//   csr        in         csr_write_enable only   prelude_length (8 bit)
//
// one byte a cycle sustained while the result register is not held full; a transaction
// is registered in the input register, and its name byte, if any, then goes to the result register
// reset clears all parser state and sets prelude_length to 22, no clearing pass
// a full result register that is not taken holds the input register, which in
// turn drops req_chan.ready; bytes that give no name byte still move on
module archive_file_name_extractor_top (
   input  logic       clock,
   input  logic       reset,
   afne_req_if.sink   req_chan,
   afne_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   // prelude length register: user must write it only while idle; not enforced
   logic [7:0] prelude_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prelude_length_ff <= afne_pkg::PRELUDE_DEFAULT;
      end else if (csr_write_enable) begin
         prelude_length_ff <= csr_write_data;
      end
   end

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic                      advance;
   logic                      out_free;
   logic                      req_take;
   afne_pkg::name_result_type result;

   // a byte leaves the input register when it makes no name byte or the
   // result register has room
   assign advance        = in_valid_ff && (!result.valid || out_free);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.archive_byte;
         in_last_ff <= req_chan.end_of_archive;
      end
   end

   // block chain walker, state moves once per processed transaction
   afne_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .archive_byte   (in_byte_ff),
      .end_of_archive (in_last_ff),
      .prelude_length (prelude_length_ff),
      .result         (result)
   );

   // result register
   afne_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && result.valid),
      .result   (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== tb/archive_file_name_extractor_top_tb.sv =====
// archive_file_name_extractor_top_tb: self-checking bench for the archive file name extractor
// depends on afne_pkg, afne_ifs and archive_file_name_extractor_top from rtl/core
// drives archive byte transactions, predicts the name bytes and checks each one in order
module archive_file_name_extractor_top_tb;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned RANDOM_BYTES = 300;
   localparam int unsigned REPORT_LIMIT = 10;

   // one archive byte as it goes onto the request channel
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stream_byte_type;

   // one name character as the block should hand it out
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } name_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'd0;

   afne_req_if req_chan ();
   afne_rsp_if rsp_chan ();

   archive_file_name_extractor_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // 20 unit period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stimulus and expectation stores
   stream_byte_type bytes_to_send [$];
   name_char_type   name_chars_due [$];
   logic [7:0]      archive_draft [$];

   // bookkeeping
   int unsigned bytes_pushed = 0;
   int unsigned bytes_accepted = 0;
   int unsigned names_checked = 0;
   int unsigned mismatches = 0;
   int unsigned archives_shipped = 0;
   int unsigned cycles_run = 0;

   // handshake pacing
   logic        req_taken = 1'b0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned send_quiet = 0;
   int unsigned rsp_quiet = 0;

   // predictor copy of the parser state and of prelude_length
   logic [7:0]  prelude_setting = afne_pkg::PRELUDE_DEFAULT;
   logic [1:0]  parse_phase = afne_pkg::PH_PRELUDE;
   logic [7:0]  prelude_seen = 8'd0;
   logic [32:0] block_pos = '0;
   logic [7:0]  block_type = 8'd0;
   logic [15:0] head_size = 16'd0;
   logic [31:0] pack_size = 32'd0;
   logic [15:0] name_len = 16'd0;

   function automatic void clear_parser();
      parse_phase  = afne_pkg::PH_PRELUDE;
      prelude_seen = 8'd0;
      block_pos    = '0;
      block_type   = 8'd0;
      head_size    = 16'd0;
      pack_size    = 32'd0;
      name_len     = 16'd0;
   endfunction

   // distance from this block's type byte to the next one
   function automatic logic [32:0] block_span();
      return {17'd0, head_size}
           + ((block_type == afne_pkg::KIND_FILE) ? {1'b0, pack_size} : 33'd0);
   endfunction

   // advance the parser by one archive byte and queue any name character it yields
   function automatic void track_archive_byte(input logic [7:0] b, input logic last);
      logic [32:0]   off;
      logic [32:0]   nxt;
      logic [32:0]   need;
      logic [32:0]   span;
      logic [32:0]   name_stop;
      logic [32:0]   stop;
      logic          is_file;
      name_char_type due;

      // prelude bytes are counted off until the configured length is reached
      if (parse_phase == afne_pkg::PH_PRELUDE) begin
         if (prelude_seen < prelude_setting) begin
            prelude_seen = prelude_seen + 8'd1;
         end else begin
            parse_phase = afne_pkg::PH_BLOCK;
            block_pos   = '0;
         end
      end

      if (parse_phase == afne_pkg::PH_BLOCK) begin
         off = block_pos;
         if (off == '0) begin
            block_type = b;
            head_size  = 16'd0;
            pack_size  = 32'd0;
            name_len   = 16'd0;
         end else if (off == afne_pkg::OFF_HEAD_LO) begin
            head_size[7:0] = b;
         end else if (off == afne_pkg::OFF_HEAD_HI) begin
            head_size[15:8] = b;
         end
         is_file = (block_type == afne_pkg::KIND_FILE);

         if (is_file) begin
            if (off >= afne_pkg::OFF_PACK_FIRST && off <= afne_pkg::OFF_PACK_LAST) begin
               case (off[3:0])
                  4'd5:    pack_size[7:0]   = b;
                  4'd6:    pack_size[15:8]  = b;
                  4'd7:    pack_size[23:16] = b;
                  default: pack_size[31:24] = b;
               endcase
            end else if (off == afne_pkg::OFF_NAMELEN_LO) begin
               name_len[7:0] = b;
            end else if (off == afne_pkg::OFF_NAMELEN_HI) begin
               name_len[15:8] = b;
            end else if (off >= afne_pkg::OFF_NAME) begin
               // name bytes at or beyond the block end are dropped
               name_stop = afne_pkg::OFF_NAME + {17'd0, name_len};
               span      = block_span();
               if (off < name_stop) begin
                  stop     = (name_stop < span) ? name_stop : span;
                  due.ch   = b;
                  due.last = (off + 33'd1 == stop);
                  name_chars_due.insert(name_chars_due.size(), due);
               end
            end
         end

         // once the step is known a zero step halts, a short one moves on at once
         nxt  = off + 33'd1;
         need = is_file ? afne_pkg::NEED_FILE : afne_pkg::NEED_OTHER;
         if (nxt >= need) begin
            span = block_span();
            if (span == '0) begin
               parse_phase = afne_pkg::PH_HALTED;
            end else if (nxt >= span) begin
               nxt = '0;
            end
         end
         block_pos = nxt;
      end

      // end of archive: byte already handled, now everything but the register clears
      if (last) begin
         clear_parser();
      end
   endfunction

   function automatic void log_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("[%0d] %s", cycles_run, what);
      end
   endfunction

   // mostly short gaps, a few long, with the odd stretch of none at all
   function automatic int unsigned pick_gap(inout int unsigned quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet != 0) begin
         quiet--;
         return 0;
      end
      if (r < 3) begin
         quiet = $urandom_range(40, 150);
         return 0;
      end
      if (r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // monitor: sample both channels at the rising edge
   always @(posedge clock) begin
      name_char_type due;
      cycles_run++;
      req_taken = 1'b0;
      if (!reset) begin
         // result channel first; a byte taken now cannot yield a name byte this edge
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (name_chars_due.size() == 0) begin
               log_mismatch($sformatf("name byte %02h end %0b with nothing expected",
                                      rsp_chan.name_byte, rsp_chan.name_end));
            end else begin
               due = name_chars_due.pop_front();
               names_checked++;
               if (rsp_chan.name_byte !== due.ch || rsp_chan.name_end !== due.last) begin
                  log_mismatch($sformatf(
                     "name byte %0d: expected %02h end %0b, got %02h end %0b",
                     names_checked, due.ch, due.last, rsp_chan.name_byte, rsp_chan.name_end));
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            req_taken = 1'b1;
            bytes_accepted++;
            track_archive_byte(req_chan.archive_byte, req_chan.end_of_archive);
         end
      end
   end

   // driver and result sink: everything changes at the falling edge
   always @(negedge clock) begin
      stream_byte_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         rsp_chan.ready <= 1'b0;
      end else begin
         // a transaction on offer stays put until it has been taken
         if (!req_chan.valid || req_taken) begin
            if (send_gap != 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (bytes_to_send.size() != 0) begin
               nxt = bytes_to_send.pop_front();
               req_chan.valid          <= 1'b1;
               req_chan.archive_byte   <= nxt.data;
               req_chan.end_of_archive <= nxt.last;
               send_gap = pick_gap(send_quiet);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         // receiver back-pressure
         if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = pick_gap(rsp_quiet);
         end
      end
   end

   // wait for every byte to be taken and every expected name byte to arrive
   task automatic settle();
      while (bytes_accepted != bytes_pushed || name_chars_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // fully idle: settled, then let bytes that yield nothing clear the pipeline
   task automatic quiesce();
      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_prelude(input logic [7:0] value);
      quiesce();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      prelude_setting = value;
   endtask

   task automatic draft_prelude(input int unsigned count);
      repeat (count) archive_draft.insert(archive_draft.size(), 8'($urandom_range(0, 255)));
   endtask

   // lay out one block; fields sit at their offsets, the rest is random filler
   task automatic draft_block(input logic [7:0] kind, input logic [15:0] head,
                              input logic [31:0] pack, input logic [15:0] nlen,
                              input int unsigned cap);
      logic [32:0] span;
      int unsigned len;
      logic [7:0]  b;
      span = {17'd0, head} + ((kind == afne_pkg::KIND_FILE) ? {1'b0, pack} : 33'd0);
      len  = (kind == afne_pkg::KIND_FILE) ? 9 : 5;
      if (span > 33'(cap)) begin
         len = cap;
      end else if (span > 33'(len)) begin
         len = span[31:0];
      end
      // after a zero step a few trailing bytes should be ignored
      if (span == '0) begin
         len += 4;
      end
      if (len > cap) begin
         len = cap;
      end
      for (int unsigned o = 0; o < len; o++) begin
         b = 8'($urandom_range(0, 255));
         if (o == 0) begin
            b = kind;
         end else if (o == afne_pkg::OFF_HEAD_LO) begin
            b = head[7:0];
         end else if (o == afne_pkg::OFF_HEAD_HI) begin
            b = head[15:8];
         end else if (kind == afne_pkg::KIND_FILE) begin
            if (o >= afne_pkg::OFF_PACK_FIRST && o <= afne_pkg::OFF_PACK_LAST) begin
               b = pack[8*(o-5) +: 8];
            end else if (o == afne_pkg::OFF_NAMELEN_LO) begin
               b = nlen[7:0];
            end else if (o == afne_pkg::OFF_NAMELEN_HI) begin
               b = nlen[15:8];
            end
         end
         archive_draft.insert(archive_draft.size(), b);
      end
   endtask

   // queue the drafted archive; optionally hold back mid-way until all names are in
   task automatic ship(input bit with_eoa, input int pause_at);
      stream_byte_type item;
      for (int i = 0; i < archive_draft.size(); i++) begin
         if (i == pause_at) begin
            settle();
         end
         item.data = archive_draft[i];
         item.last = with_eoa && (i == archive_draft.size() - 1);
         bytes_to_send.insert(bytes_to_send.size(), item);
         bytes_pushed++;
      end
      archive_draft.delete();
      archives_shipped++;
   endtask

   initial begin
      logic [7:0]  other_kind;
      logic [15:0] nlen;
      int unsigned random_sent;
      int unsigned blocks;
      int unsigned r;
      int          base;
      int          pause_at;
      bit          stop_blocks;

      req_chan.valid          = 1'b0;
      req_chan.archive_byte   = 8'd0;
      req_chan.end_of_archive = 1'b0;
      rsp_chan.ready          = 1'b0;
      random_sent             = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----

      // reset prelude length, one clean file entry with extreme name characters,
      // then a plain block; held back after the first name character to let it drain
      draft_prelude(22);
      base = archive_draft.size();
      draft_block(afne_pkg::KIND_FILE, 16'd34, 32'd2, 16'd4, 1000);
      archive_draft[base + 30] = 8'hFF;
      archive_draft[base + 31] = 8'h00;
      draft_block(8'h7A, 16'd6, 32'd0, 16'd0, 1000);
      ship(1'b1, base + 31);

      // no prelude: empty name, name running past the head end, a step shorter than the
      // header, name cut by the pack area end, then a zero step halt
      set_prelude(8'd0);
      draft_block(afne_pkg::KIND_FILE, 16'd32, 32'd0, 16'd0, 1000);
      draft_block(afne_pkg::KIND_FILE, 16'd35, 32'd0, 16'hFFFF, 1000);
      draft_block(8'h73, 16'd3, 32'd0, 16'd0, 1000);
      draft_block(afne_pkg::KIND_FILE, 16'd40, 32'd1, 16'd20, 1000);
      draft_block(8'h7B, 16'd0, 32'd0, 16'd0, 1000);
      ship(1'b1, -1);

      // end of archive inside the prelude
      set_prelude(8'd5);
      draft_prelude(3);
      ship(1'b1, -1);

      // stop mid-prelude, shorten the prelude, a one-character file entry, then a huge
      // file block whose archive ends on a name character
      draft_prelude(3);
      ship(1'b0, -1);
      set_prelude(8'd1);
      draft_block(afne_pkg::KIND_FILE, 16'd31, 32'd0, 16'd1, 1000);
      draft_block(afne_pkg::KIND_FILE, 16'hFFFF, 32'hFFFF_FFFF, 16'd3, 33);
      ship(1'b1, -1);

      // longest prelude
      set_prelude(8'd255);
      draft_prelude(255);
      draft_block(afne_pkg::KIND_FILE, 16'd31, 32'd0, 16'd1, 1000);
      ship(1'b1, -1);

      // ---- random part: mostly well-formed archives, some broken ones ----
      while (random_sent < RANDOM_BYTES) begin
         if (archives_shipped % 3 == 0) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
               set_prelude(8'd0);
            end else if (r < 30) begin
               set_prelude(8'($urandom_range(41, 80)));
            end else begin
               set_prelude(8'($urandom_range(1, 40)));
            end
         end
         draft_prelude(32'(prelude_setting));
         blocks      = $urandom_range(1, 4);
         stop_blocks = 1'b0;
         for (int unsigned k = 0; k < blocks && !stop_blocks; k++) begin
            r = $urandom_range(0, 99);
            other_kind = 8'($urandom_range(0, 255));
            if (other_kind == afne_pkg::KIND_FILE) begin
               other_kind = 8'h7A;
            end
            if (r < 65) begin
               nlen = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
               draft_block(afne_pkg::KIND_FILE,
                           16'd30 + nlen + 16'($urandom_range(0, 3)),
                           32'($urandom_range(0, 6)), nlen, 1000);
            end else if (r < 80) begin
               draft_block(other_kind, 16'($urandom_range(5, 12)), 32'd0, 16'd0, 1000);
            end else if (r < 85) begin
               draft_block(afne_pkg::KIND_FILE, 16'($urandom_range(30, 40)),
                           32'($urandom_range(0, 3)),
                           16'($urandom_range(0, 65535)), 1000);
            end else if (r < 90) begin
               draft_block(r[0] ? afne_pkg::KIND_FILE : other_kind,
                           16'($urandom_range(1, 4)), 32'd0, 16'd0, 1000);
            end else if (r < 94) begin
               draft_block(r[0] ? afne_pkg::KIND_FILE : other_kind,
                           16'd0, 32'd0, 16'd0, 1000);
            end else begin
               // step far beyond the archive end; nothing after it matters
               draft_block(afne_pkg::KIND_FILE, 16'($urandom_range(0, 65535)), $urandom(),
                           16'($urandom_range(0, 65535)), $urandom_range(20, 60));
               stop_blocks = 1'b1;
            end
         end
         random_sent += archive_draft.size();
         pause_at = (archives_shipped == 6) ? archive_draft.size() / 2 : -1;
         ship($urandom_range(0, 9) != 0, pause_at);
      end

      // ---- wind down ----
      quiesce();
      $display("run covered %0d archive bytes in %0d archives, prelude lengths 0 to 255",
               bytes_accepted, archives_shipped);
      $display("%0d name bytes checked, %0d failures", names_checked, mismatches);
      if (mismatches == 0) begin
         $display("archive_file_name_extractor_top: match");
      end else begin
         $display("archive_file_name_extractor_top: mismatch");
      end
      $finish;
   end

   // watchdog on the cycle count
   initial begin
      wait (cycles_run >= CYCLE_LIMIT);
      $display("timed out after %0d cycles with %0d name bytes outstanding",
               cycles_run, name_chars_due.size());
      $display("archive_file_name_extractor_top: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/afne_pkg.sv
rtl/core/afne_ifs.sv
rtl/core/afne_parse.sv
rtl/core/afne_out_reg.sv
rtl/core/archive_file_name_extractor_top.sv
tb/archive_file_name_extractor_top_tb.sv
